@@ hdl/mrby_pkg.sv @@
// Shared types, constants and arithmetic helpers of the marker range/bearing/yaw core.
package mrby_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int SQRT_STEPS        = 32;
	localparam int NORM_STEPS        = 6;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 25;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_BASELINE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIENT_OFFSET = 1'b1;

	localparam logic [16:0]        HALF_BASELINE_RST = 17'd3932;
	localparam logic signed [24:0] ORIENT_OFFSET_RST = 25'sd5898240;

	localparam logic signed [33:0] DEG90_Q24  = 34'sd1509949440;
	localparam logic signed [33:0] DEG180_Q24 = 34'sd3019898880;
	localparam logic signed [33:0] ROUND_HALF = 34'sd128;
	localparam logic signed [33:0] BEAR_LIM   = 34'sd5898240;
	localparam logic signed [33:0] YAW_LIM    = 34'sd11796480;

	typedef enum logic [1:0] {SEL_CORDIC, SEL_POS90, SEL_NEG90, SEL_ZERO} ang_sel_t;
	typedef enum logic [1:0] {OFS_NONE, OFS_POS180, OFS_NEG180} yofs_t;

	// One vectoring lane: magnitude bound, vector and accumulated angle (degrees Q.24).
	typedef struct packed {
		logic [63:0]        m;
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [33:0] z;
	} lane_t;

	typedef struct packed {
		logic        vld;
		logic [63:0] sq_n;
		logic [63:0] sq_r;
		lane_t       brg;
		lane_t       yaw;
		ang_sel_t    bsel;
		ang_sel_t    ysel;
		yofs_t       yofs;
	} core_t;

	// atan(2^-i) in degrees, Q.24.
	function automatic logic [29:0] atan_deg(input int unsigned i);
		logic [29:0] v;
		unique case (i)
			0: v = 30'd754974720;
			1: v = 30'd445687602;
			2: v = 30'd235489088;
			3: v = 30'd119537938;
			4: v = 30'd60000934;
			5: v = 30'd30029717;
			6: v = 30'd15018523;
			7: v = 30'd7509720;
			8: v = 30'd3754917;
			9: v = 30'd1877466;
			10: v = 30'd938734;
			11: v = 30'd469367;
			12: v = 30'd234684;
			13: v = 30'd117342;
			14: v = 30'd58671;
			15: v = 30'd29335;
			16: v = 30'd14668;
			17: v = 30'd7334;
			18: v = 30'd3667;
			19: v = 30'd1833;
			20: v = 30'd917;
			21: v = 30'd458;
			22: v = 30'd229;
			23: v = 30'd115;
			24: v = 30'd57;
			25: v = 30'd29;
			26: v = 30'd14;
			27: v = 30'd7;
			28: v = 30'd4;
			29: v = 30'd2;
			30: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

	// One step of the binary search that brings the larger operand up to bit 59.
	function automatic lane_t norm_step(input lane_t a, input int unsigned s);
		lane_t       r;
		logic [63:0] lim;
		r   = a;
		lim = 64'd1 << (60 - s);
		if (a.m < lim) begin
			r.m = a.m << s;
			r.x = a.x <<< s;
			r.y = a.y <<< s;
		end
		return r;
	endfunction

	function automatic lane_t cordic_iter(input lane_t a, input int unsigned i);
		lane_t              r;
		logic signed [63:0] dx;
		logic signed [63:0] dy;
		logic signed [33:0] t;
		r  = a;
		dx = a.y >>> i;
		dy = a.x >>> i;
		t  = $signed({4'b0, atan_deg(i)});
		if (!a.y[63]) begin
			r.x = a.x + dx;
			r.y = a.y - dy;
			r.z = a.z + t;
		end else begin
			r.x = a.x - dx;
			r.y = a.y + dy;
			r.z = a.z - t;
		end
		return r;
	endfunction

endpackage

@@ hdl/mrby_if.sv @@
// Valid/ready channel interfaces for poses in and results out.
interface mrby_pose_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [15:0] quat_a;
	logic signed [15:0] quat_b;
	logic signed [15:0] quat_c;
	logic signed [15:0] quat_d;

	modport source (output valid, pos_x, pos_y, quat_a, quat_b, quat_c, quat_d, input ready);
	modport sink (input valid, pos_x, pos_y, quat_a, quat_b, quat_c, quat_d, output ready);
endinterface

interface mrby_result_if;
	logic               valid;
	logic               ready;
	logic [31:0]        range_out;
	logic signed [23:0] bearing_deg;
	logic signed [25:0] heading_deg;

	modport source (output valid, range_out, bearing_deg, heading_deg, input ready);
	modport sink (input valid, range_out, bearing_deg, heading_deg, output ready);
endinterface

@@ hdl/marker_range_bearing_yaw_core.sv @@
// Top level of the marker range, bearing and heading pipeline.
// A pose passes stages 1 to 3, the core chain and the output register on its way to a result.
// Throughput: one pose per cycle unless stalled; 32-step square root and CORDIC chains set depth.
// A stalled result holds the whole pipeline in place; nothing is dropped or repeated.
// Reset (arst_n low, asynchronous) clears all valid bits and loads the register defaults.
module marker_range_bearing_yaw_core #(
	parameter int CORDIC_STAGES = mrby_pkg::CORDIC_STAGES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mrby_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mrby_pkg::CFG_DATA_W-1:0]     cfg_data,
	mrby_pose_if.sink                           pose,
	mrby_result_if.source                       result
);
	import mrby_pkg::*;

	// Core depth covers whichever of the square root and the angle chains is longer.
	localparam int NC = (SQRT_STEPS > NORM_STEPS + CORDIC_STAGES) ?
		SQRT_STEPS : (NORM_STEPS + CORDIC_STAGES);

	// Configuration registers. Write them only while the pipeline is empty; the block does not enforce it.
	logic [16:0]        hb_q;
	logic signed [24:0] ofs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_q  <= HALF_BASELINE_RST;
			ofs_q <= ORIENT_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_BASELINE: hb_q  <= cfg_data[16:0];
				REG_ORIENT_OFFSET: ofs_q <= $signed(cfg_data[24:0]);
			endcase
		end
	end

	// Every stage advances together unless the output register holds an untaken result.
	logic res_vld_q;
	logic en;
	assign en         = !res_vld_q || result.ready;
	assign pose.ready = en;

	// Stage 1: apply the half baseline and form the quaternion products.
	logic               vld_s1;
	logic signed [31:0] x_s1;
	logic signed [32:0] y_s1;
	logic signed [31:0] ab_s1, cd_s1, bb_s1, cc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pose.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1  <= pose.pos_x;
			y_s1  <= $signed({pose.pos_y[31], pose.pos_y}) + $signed({16'b0, hb_q});
			ab_s1 <= pose.quat_a * pose.quat_b;
			cd_s1 <= pose.quat_c * pose.quat_d;
			bb_s1 <= pose.quat_b * pose.quat_b;
			cc_s1 <= pose.quat_c * pose.quat_c;
		end
	end

	// Stage 2: squares of the magnitudes, yaw operands and the folded bearing vector.
	logic [31:0]        ax_c;
	logic [32:0]        ay_c;
	logic [65:0]        yy_full;
	logic signed [32:0] qn_c, qd_c;
	logic signed [63:0] ysx_c;
	ang_sel_t           bsel_c;

	logic               vld_s2;
	logic [63:0]        xx_s2, yy_s2;
	logic signed [33:0] num_s2, den_s2;
	logic signed [63:0] bx_s2, by_s2;
	logic [63:0]        bm_s2;
	ang_sel_t           bsel_s2;

	always_comb begin
		ax_c    = x_s1[31] ? (~x_s1 + 32'd1) : x_s1;
		ay_c    = y_s1[32] ? (~y_s1 + 33'd1) : y_s1;
		yy_full = ay_c * ay_c;
		qn_c    = $signed({ab_s1[31], ab_s1}) + $signed({cd_s1[31], cd_s1});
		qd_c    = $signed({bb_s1[31], bb_s1}) + $signed({cc_s1[31], cc_s1});
		ysx_c   = {{31{y_s1[32]}}, y_s1};
		if (x_s1 != 32'sd0) begin
			bsel_c = SEL_CORDIC;
		end else if (y_s1[32]) begin
			bsel_c = SEL_NEG90;
		end else if (y_s1 != 33'sd0) begin
			bsel_c = SEL_POS90;
		end else begin
			bsel_c = SEL_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s2   <= ax_c * ax_c;
			yy_s2   <= yy_full[63:0];
			num_s2  <= {qn_c, 1'b0};
			den_s2  <= 34'sd268435456 - $signed({qd_c, 1'b0});
			bx_s2   <= $signed({32'b0, ax_c});
			by_s2   <= x_s1[31] ? -ysx_c : ysx_c;
			bm_s2   <= (ax_c > ay_c) ? {32'b0, ax_c} : {31'b0, ay_c};
			bsel_s2 <= bsel_c;
		end
	end

	// Stage 3: square sum, yaw vector folded into the right half plane, core input.
	logic signed [33:0] aden_c, anum_c;
	ang_sel_t           ysel_c;
	yofs_t              yofs_c;
	logic               vld_s3;
	core_t              core_s3;
	core_t              core_in;

	always_comb begin
		aden_c = den_s2[33] ? -den_s2 : den_s2;
		anum_c = num_s2[33] ? -num_s2 : num_s2;
		if (den_s2 != 34'sd0) begin
			ysel_c = SEL_CORDIC;
		end else if (num_s2[33]) begin
			ysel_c = SEL_NEG90;
		end else if (num_s2 != 34'sd0) begin
			ysel_c = SEL_POS90;
		end else begin
			ysel_c = SEL_ZERO;
		end
		if (!den_s2[33]) begin
			yofs_c = OFS_NONE;
		end else if (num_s2[33]) begin
			yofs_c = OFS_NEG180;
		end else begin
			yofs_c = OFS_POS180;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			core_s3.vld   <= 1'b0;
			core_s3.sq_n  <= xx_s2 + yy_s2;
			core_s3.sq_r  <= 64'd0;
			core_s3.brg.m <= bm_s2;
			core_s3.brg.x <= bx_s2;
			core_s3.brg.y <= by_s2;
			core_s3.brg.z <= 34'sd0;
			core_s3.yaw.m <= (aden_c > anum_c) ? {30'b0, aden_c} : {30'b0, anum_c};
			core_s3.yaw.x <= {{30{aden_c[33]}}, aden_c};
			core_s3.yaw.y <= den_s2[33] ? -{{30{num_s2[33]}}, num_s2} :
				{{30{num_s2[33]}}, num_s2};
			core_s3.yaw.z <= 34'sd0;
			core_s3.bsel  <= bsel_s2;
			core_s3.ysel  <= ysel_c;
			core_s3.yofs  <= yofs_c;
		end
	end

	always_comb begin
		core_in     = core_s3;
		core_in.vld = vld_s3;
	end

	// Core chain: square root steps run alongside normalization and CORDIC iterations.
	core_t chain [0:NC];
	assign chain[0] = core_in;

	for (genvar j = 0; j < NC; j++) begin : g_core
		mrby_step #(
			.J             (j),
			.CORDIC_STAGES (CORDIC_STAGES)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.d      (chain[j]),
			.q      (chain[j+1])
		);
	end

	// Output stage: special angles, the half turn for a negative denominator, rounding
	// from Q.24 to Q.16 half up, limiting, and the orientation offset.
	core_t              fin;
	logic signed [33:0] bz_c, yz_c, yb_c, br_c, yr_c;
	logic signed [33:0] bcl_c, ycl_c;
	logic signed [25:0] head_c;

	assign fin = chain[NC];

	always_comb begin
		unique case (fin.bsel)
			SEL_CORDIC: bz_c = fin.brg.z;
			SEL_POS90:  bz_c = DEG90_Q24;
			SEL_NEG90:  bz_c = -DEG90_Q24;
			SEL_ZERO:   bz_c = 34'sd0;
		endcase
		unique case (fin.ysel)
			SEL_CORDIC: yb_c = fin.yaw.z;
			SEL_POS90:  yb_c = DEG90_Q24;
			SEL_NEG90:  yb_c = -DEG90_Q24;
			SEL_ZERO:   yb_c = 34'sd0;
		endcase
		unique case (fin.yofs)
			OFS_POS180: yz_c = yb_c + DEG180_Q24;
			OFS_NEG180: yz_c = yb_c - DEG180_Q24;
			default:    yz_c = yb_c;
		endcase
		br_c = (bz_c + ROUND_HALF) >>> 8;
		yr_c = (yz_c + ROUND_HALF) >>> 8;
		if (br_c > BEAR_LIM) begin
			bcl_c = BEAR_LIM;
		end else if (br_c < -BEAR_LIM) begin
			bcl_c = -BEAR_LIM;
		end else begin
			bcl_c = br_c;
		end
		if (yr_c > YAW_LIM) begin
			ycl_c = YAW_LIM;
		end else if (yr_c < -YAW_LIM) begin
			ycl_c = -YAW_LIM;
		end else begin
			ycl_c = yr_c;
		end
		head_c = $signed({ofs_q[24], ofs_q}) + ycl_c[25:0];
	end

	logic [31:0]        range_q;
	logic signed [23:0] bearing_q;
	logic signed [25:0] heading_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			range_q   <= fin.sq_r[31:0];
			bearing_q <= bcl_c[23:0];
			heading_q <= head_c;
		end
	end

	assign result.valid       = res_vld_q;
	assign result.range_out   = range_q;
	assign result.bearing_deg = bearing_q;
	assign result.heading_deg = heading_q;

endmodule

@@ hdl/mrby_step.sv @@
// One core pipeline stage: a square root step, a normalize step or a CORDIC iteration.
module mrby_step #(
	parameter int J             = 0,
	parameter int CORDIC_STAGES = mrby_pkg::CORDIC_STAGES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  mrby_pkg::core_t d,
	output mrby_pkg::core_t q
);
	import mrby_pkg::*;

	localparam int          SQ_SH     = (J < SQRT_STEPS) ? (62 - 2 * J) : 0;
	localparam logic [63:0] SQ_BIT    = 64'd1 << SQ_SH;
	localparam int          NS        = (J < NORM_STEPS) ? (32 >> J) : 0;
	localparam bit          DO_CORDIC = (J >= NORM_STEPS) && (J < NORM_STEPS + CORDIC_STAGES);
	localparam int          CI        = DO_CORDIC ? (J - NORM_STEPS) : 0;

	core_t       nxt;
	core_t       dat_q;
	logic        vld_q;
	logic [63:0] trial;

	always_comb begin
		nxt   = d;
		trial = d.sq_r + SQ_BIT;
		if (J < SQRT_STEPS) begin
			if (d.sq_n >= trial) begin
				nxt.sq_n = d.sq_n - trial;
				nxt.sq_r = (d.sq_r >> 1) + SQ_BIT;
			end else begin
				nxt.sq_r = d.sq_r >> 1;
			end
		end
		if (J < NORM_STEPS) begin
			nxt.brg = norm_step(d.brg, NS);
			nxt.yaw = norm_step(d.yaw, NS);
		end else if (DO_CORDIC) begin
			nxt.brg = cordic_iter(d.brg, CI);
			nxt.yaw = cordic_iter(d.yaw, CI);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= d.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_q <= nxt;
		end
	end

	always_comb begin
		q     = dat_q;
		q.vld = vld_q;
	end

endmodule

@@ test/mrby_checker.sv @@
// Scoreboard for the marker range/bearing/yaw core: predicts each pose and compares results.
module mrby_checker
	import mrby_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mrby_pose_if                  pose,
	mrby_result_if                result,
	output int                    fail_count,
	output int                    outstanding
);

	typedef struct {
		logic [31:0]        range_out;
		logic signed [23:0] bearing_deg;
		logic signed [25:0] heading_deg;
	} pose_result_t;

	localparam longint Q24_90  = 64'sd1509949440;
	localparam longint Q24_180 = 64'sd3019898880;
	localparam longint BRG_MAX = 64'sd5898240;
	localparam longint YAW_MAX = 64'sd11796480;

	// atan(2^-i) in degrees Q.24 for the sixteen vectoring stages.
	localparam longint ATAN_Q24 [16] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717, 15018523, 7509720,
		3754917, 1877466, 938734, 469367, 234684, 117342, 58671, 29335
	};

	pose_result_t       result_q[$];
	logic [16:0]        baseline;
	logic signed [24:0] heading_ofs;

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Angle of (x, y) for x > 0, after normalizing so the larger operand sits near bit 59.
	function automatic longint vector_angle(input longint x, input longint y);
		longint unsigned m;
		longint unsigned ay;
		longint          dx;
		longint          dy;
		longint          z;
		int              k;
		ay = (y < 0) ? -y : y;
		m  = x;
		if (ay > m)
			m = ay;
		k = 0;
		while (m < (64'd1 << 59) && k < 62) begin
			m <<= 1;
			k++;
		end
		x = x <<< k;
		y = y <<< k;
		z = 0;
		for (int i = 0; i < 16; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += ATAN_Q24[i];
			end else begin
				x -= dx;
				y += dy;
				z -= ATAN_Q24[i];
			end
		end
		return z;
	endfunction

	function automatic longint round_clamp(input longint z, input longint lim);
		longint r;
		r = (z + 128) >>> 8;
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r;
	endfunction

	function automatic pose_result_t predict_pose(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [15:0] qa,
			input logic signed [15:0] qb, input logic signed [15:0] qc,
			input logic signed [15:0] qd);
		pose_result_t    p;
		longint          x;
		longint          y;
		longint          num;
		longint          den;
		longint          bz;
		longint          yz;
		longint          bear;
		longint          head;
		longint unsigned rng;
		x   = longint'(px);
		y   = longint'(py) + longint'({47'd0, baseline});
		rng = floor_sqrt(longint'(x * x) + longint'(y * y));
		if (rng > 64'hFFFF_FFFF)
			rng = 64'hFFFF_FFFF;
		if (x == 0)
			bz = (y > 0) ? Q24_90 : ((y < 0) ? -Q24_90 : 0);
		else if (x > 0)
			bz = vector_angle(x, y);
		else
			bz = vector_angle(-x, -y);
		num = 2 * (longint'(qa) * longint'(qb) + longint'(qc) * longint'(qd));
		den = (64'sd1 << 28) - 2 * (longint'(qb) * longint'(qb) + longint'(qc) * longint'(qc));
		if (den > 0)
			yz = vector_angle(den, num);
		else if (den < 0)
			yz = vector_angle(-den, -num) + ((num >= 0) ? Q24_180 : -Q24_180);
		else
			yz = (num > 0) ? Q24_90 : ((num < 0) ? -Q24_90 : 0);
		bear          = round_clamp(bz, BRG_MAX);
		head          = longint'(heading_ofs) + round_clamp(yz, YAW_MAX);
		p.range_out   = rng[31:0];
		p.bearing_deg = bear[23:0];
		p.heading_deg = head[25:0];
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pose_result_t want;
		if (!arst_n) begin
			result_q.delete();
			baseline    = HALF_BASELINE_RST;
			heading_ofs = ORIENT_OFFSET_RST;
			fail_count  = 0;
		end else begin
			if (pose.valid && pose.ready)
				result_q.push_back(predict_pose(pose.pos_x, pose.pos_y, pose.quat_a,
					pose.quat_b, pose.quat_c, pose.quat_d));
			if (result.valid && result.ready) begin
				if (result_q.size() == 0) begin
					$error("unexpected result transaction: range_out %h", result.range_out);
					fail_count++;
				end else begin
					want = result_q.pop_front();
					if (result.range_out !== want.range_out) begin
						$error("range_out: expected %0d, got %0d", want.range_out,
							result.range_out);
						fail_count++;
					end
					if (result.bearing_deg !== want.bearing_deg) begin
						$error("bearing_deg: expected %0d, got %0d", want.bearing_deg,
							result.bearing_deg);
						fail_count++;
					end
					if (result.heading_deg !== want.heading_deg) begin
						$error("heading_deg: expected %0d, got %0d", want.heading_deg,
							result.heading_deg);
						fail_count++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == REG_HALF_BASELINE)
					baseline = cfg_data[16:0];
				else if (cfg_index == REG_ORIENT_OFFSET)
					heading_ofs = cfg_data[24:0];
			end
		end
		outstanding = result_q.size();
	end

endmodule

@@ test/tb_marker_range_bearing_yaw_core.sv @@
// Stimulus and verdict for the marker range/bearing/yaw core testbench.
module tb_marker_range_bearing_yaw_core;
	import mrby_pkg::*;

	// Generous bound on the whole run; the slowest legal run stays far below it.
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    outstanding;
	int                    cycle_count;
	int                    src_idle_pct;
	int                    dst_stall_pct;
	int                    hold_len;
	logic                  hold_req;

	mrby_pose_if   pose_ch();
	mrby_result_if result_ch();

	marker_range_bearing_yaw_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pose      (pose_ch),
		.result    (result_ch)
	);

	mrby_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pose        (pose_ch),
		.result      (result_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// The run is cut off if it ever hangs, for instance on a handshake that never completes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// The result side stalls at random. A long hold-off, counted here once it is requested,
	// lets the pipeline fill up so that the core has to push back on pose transactions.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b1;
			hold_len        <= 0;
		end else if (hold_req && hold_len < HOLD_CYCLES) begin
			result_ch.ready <= 1'b0;
			hold_len        <= hold_len + 1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= dst_stall_pct);
		end
	end

	// Offer one pose and wait for its transaction. Valid stays high after acceptance so
	// that back-to-back poses never lower and raise it within the same time step.
	task automatic drive_pose(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [15:0] a, input logic signed [15:0] b,
			input logic signed [15:0] c, input logic signed [15:0] d);
		int gap;
		gap = 0;
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct && gap < 30)
			gap++;
		if (gap > 0) begin
			pose_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pose_ch.valid  <= 1'b1;
		pose_ch.pos_x  <= x;
		pose_ch.pos_y  <= y;
		pose_ch.quat_a <= a;
		pose_ch.quat_b <= b;
		pose_ch.quat_c <= c;
		pose_ch.quat_d <= d;
		do
			@(posedge clk);
		while (!pose_ch.ready);
	endtask

	function automatic logic signed [31:0] rand_position();
		logic signed [31:0] v;
		v = $urandom();
		// Most positions are a few metres; the rest span the full width or are tiny.
		case ($urandom_range(5))
			0, 1:    v = v >>> 8;
			2:       v = v >>> $urandom_range(31, 12);
			3:       v = v >>> 14;
			default: v = v;
		endcase
		return v;
	endfunction

	function automatic logic signed [15:0] rand_quat();
		if ($urandom_range(9) == 0)
			return 16'($urandom());
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	// Registers may only change while the pipeline is empty.
	task automatic set_registers(input logic [16:0] baseline, input logic signed [24:0] ofs);
		pose_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HALF_BASELINE;
		cfg_data  <= {8'd0, baseline};
		@(posedge clk);
		cfg_index <= REG_ORIENT_OFFSET;
		cfg_data  <= ofs;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [16:0]        baseline;
		logic signed [24:0] ofs;
		hold_req         = 1'b0;
		src_idle_pct     = 0;
		dst_stall_pct    = 0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_HALF_BASELINE;
		cfg_data         = '0;
		pose_ch.valid    = 1'b0;
		pose_ch.pos_x    = '0;
		pose_ch.pos_y    = '0;
		pose_ch.quat_a   = '0;
		pose_ch.quat_b   = '0;
		pose_ch.quat_c   = '0;
		pose_ch.quat_d   = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed poses with the reset register values (half baseline 3932).
		drive_pose(0, -3932, 0, 0, 0, 16384);                 // x and y both zero
		drive_pose(0, 65536, 0, 0, 0, 0);                     // zero x, y positive
		drive_pose(0, -65536, 0, 0, 0, 0);                    // zero x, y negative
		drive_pose(-32'sd65536, 32'sd131072, 0, 0, 0, 16384); // negative x
		drive_pose(-32'sd2147483648, 32'sd2147483647, 16384, 0, 0, 0);
		drive_pose(32'sd2147483647, -32'sd2147483648, -16384, 0, 0, 0);
		drive_pose(-32'sd2147483648, -32'sd2147483648, 0, 0, 0, 0);
		drive_pose(32'sd2147483647, 32'sd2147483647, 0, 16384, 0, 0);
		drive_pose(1, 0, 0, 16384, 0, 16384);                 // negative yaw denominator
		drive_pose(1, 1, 16384, 16384, 0, 0);
		drive_pose(5, -3, -16384, 16384, 0, 0);               // negative denominator and numerator
		drive_pose(100, 7, 0, 8192, 8192, 0);                 // zero yaw operands
		drive_pose(-100, 7, 16384, 8192, 8192, 0);            // zero denominator, positive numerator
		drive_pose(100, -7, -16384, 8192, 8192, 0);           // zero denominator, negative numerator
		drive_pose(3, 3, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
		drive_pose(-3, -3, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
		drive_pose(-32'sd1, -32'sd1, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
		drive_pose(32'sd65536, 32'sd0, 0, 0, 16384, 16384);
		drive_pose(32'sd1, 32'sd2147483647, 0, 0, 11585, 11585);

		// Each phase picks an idling pattern and a register setting, extremes first.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       begin baseline = 17'd0;     ofs = -25'sd11796480; end
				1:       begin baseline = 17'd65536; ofs = 25'sd11796480;  end
				2:       begin baseline = 17'd3932;  ofs = 25'sd5898240;   end
				3:       begin baseline = 17'd1;     ofs = 25'sd0;         end
				default: begin
					baseline = 17'($urandom_range(65536));
					ofs      = 25'($signed($urandom_range(23592960)) - 11796480);
				end
			endcase
			set_registers(baseline, ofs);
			case (phase % 4)
				0:       begin src_idle_pct = 0;  dst_stall_pct = 0;  end
				1:       begin src_idle_pct = 70; dst_stall_pct = 0;  end
				2:       begin src_idle_pct = 0;  dst_stall_pct = 70; end
				default: begin src_idle_pct = 36; dst_stall_pct = 36; end
			endcase
			for (int n = 0; n < 175; n++) begin
				// In the first phase the receiver goes quiet for a while so the core backs up.
				if (phase == 0 && n == 20)
					hold_req = 1'b1;
				drive_pose(rand_position(), rand_position(), rand_quat(), rand_quat(),
					rand_quat(), rand_quat());
			end
		end

		pose_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
